### rtl/miq_pkg.sv
// ----------------------------------------------------------------------------
// miq_pkg
// Shared types and constants for the middle insert queue.
// ----------------------------------------------------------------------------
package miq_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_JOIN  = 2'd0,
    CMD_CUT   = 2'd1,
    CMD_SERVE = 2'd2,
    CMD_DROP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CH_HOLD   = 2'd0,
    CH_INSERT = 2'd1,
    CH_POP    = 2'd2
  } chain_op_t;

  typedef struct packed {
    chain_op_t          op;
    logic [DATA_W-1:0]  value;
  } chain_ctl_t;

endpackage

### rtl/miq_cell.sv
// ----------------------------------------------------------------------------
// miq_cell
// One storage slot of the queue chain. Holds, loads the inserted value,
// takes its lower neighbor on an insert below it, or its upper neighbor on
// a pop from the head.
// ----------------------------------------------------------------------------
module miq_cell
  import miq_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int PW    = 7
) (
  input  logic              clk,
  input  chain_ctl_t        ctl,
  input  logic [PW-1:0]     pos,
  input  logic [DATA_W-1:0] lower,
  input  logic [DATA_W-1:0] upper,
  output logic [DATA_W-1:0] q
);

  localparam logic [PW-1:0] MY_POS = PW'(INDEX);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CH_INSERT: begin
        if (pos == MY_POS) begin
          q <= ctl.value;
        end else if (pos < MY_POS) begin
          q <= lower;
        end
      end
      CH_POP: begin
        q <= upper;
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

### rtl/miq_chain.sv
// ----------------------------------------------------------------------------
// miq_chain
// Row of cells holding the whole queue in order, head at cell zero. The
// front half occupies the low cells and the back half follows it, so the
// boundary between halves is a count, not a data move.
// ----------------------------------------------------------------------------
module miq_chain
  import miq_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int PW    = 7
) (
  input  logic              clk,
  input  chain_ctl_t        ctl,
  input  logic [PW-1:0]     pos,
  output logic [DATA_W-1:0] head
);

  logic [DATA_W-1:0] cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_q[i+1];
    end

    miq_cell #(
      .INDEX (i),
      .PW    (PW)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .pos   (pos),
      .lower (lower),
      .upper (upper),
      .q     (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule

### rtl/middle_insert_queue.sv
// ----------------------------------------------------------------------------
// middle_insert_queue
// Queue with inserts at its back and at its middle, kept as a front half and
// a back half of HALF_DEPTH entries each.
//
// Usage: drive command, limit and entry_value with start high; the command
// is taken at any rising edge where start is high and busy is low. busy is
// never raised: every command completes in the cycle it is taken, so the
// block sustains one command per clock.
// Commands: join at back, cut into middle, serve front, drop last. Inserts
// are checked against limit and dropped when the target half is full; the
// halves are then rebalanced by moving the boundary by one slot.
// Results: only serve gives a transaction. It appears in the cycle after the
// command is taken, with done high for exactly one cycle; served_value holds
// the head entry, or zero with is_empty high when the queue was empty. The
// receiver cannot stall, so results are never held back.
// Storage is a chain of 2*HALF_DEPTH cells whose shift is registered at the
// same clock edge as the update of the half counts.
// Reset (rst, synchronous) empties both halves and clears done; cell
// contents are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module middle_insert_queue
  import miq_pkg::*;
#(
  parameter int HALF_DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               command,
  input  logic [7:0]               limit,
  input  logic signed [DATA_W-1:0] entry_value,
  output logic                     done,
  output logic signed [DATA_W-1:0] served_value,
  output logic                     is_empty
);

  localparam int CW   = $clog2(HALF_DEPTH + 1);
  localparam int TW   = $clog2(2 * HALF_DEPTH + 1);
  localparam int PW   = $clog2(2 * HALF_DEPTH);
  localparam int CMPW = (TW > 8) ? TW : 8;
  localparam logic [CW-1:0] FULL = CW'(HALF_DEPTH);

  logic [CW-1:0]     front_count;
  logic [CW-1:0]     back_count;
  logic [CW-1:0]     front_count_next;
  logic [CW-1:0]     back_count_next;
  logic              done_next;
  logic [DATA_W-1:0] served_next;
  logic              empty_next;
  logic [TW-1:0]     total;
  logic              take;
  chain_ctl_t        ctl;
  logic [PW-1:0]     pos;
  logic [DATA_W-1:0] head;

  assign busy  = 1'b0;
  assign take  = start && !busy;
  assign total = TW'(front_count) + TW'(back_count);

  always_comb begin
    logic          ins_req;
    logic          to_front;
    logic [CW-1:0] fc;
    logic [CW-1:0] bc;

    ins_req          = 1'b0;
    to_front         = 1'b0;
    fc               = front_count;
    bc               = back_count;
    pos              = PW'(front_count);
    ctl.op           = CH_HOLD;
    ctl.value        = entry_value;
    front_count_next = front_count;
    back_count_next  = back_count;
    done_next        = 1'b0;
    served_next      = '0;
    empty_next       = 1'b0;

    if (take) begin
      case (cmd_t'(command))
        CMD_JOIN: begin
          if (CMPW'(total) < CMPW'(limit)) begin
            ins_req = 1'b1;
            if (front_count == '0) begin
              to_front = 1'b1;
              pos      = PW'(front_count);
            end else begin
              pos = total[PW-1:0];
            end
          end
        end
        CMD_CUT: begin
          if (CMPW'(front_count) < CMPW'(limit)) begin
            ins_req  = 1'b1;
            to_front = !(front_count > back_count);
            pos      = PW'(front_count);
          end
        end
        CMD_SERVE: begin
          done_next = 1'b1;
          if (total == '0) begin
            empty_next = 1'b1;
          end else begin
            served_next = head;
            ctl.op      = CH_POP;
            if (front_count != '0) begin
              front_count_next = front_count - CW'(1);
            end else begin
              back_count_next = back_count - CW'(1);
            end
          end
        end
        CMD_DROP: begin
          if (back_count != '0) begin
            back_count_next = back_count - CW'(1);
          end else if (front_count != '0) begin
            front_count_next = front_count - CW'(1);
          end
        end
        default: begin
          ins_req = 1'b0;
        end
      endcase
    end

    if (ins_req) begin
      if (to_front && front_count != FULL) begin
        fc     = front_count + CW'(1);
        ctl.op = CH_INSERT;
      end else if (!to_front && back_count != FULL) begin
        bc     = back_count + CW'(1);
        ctl.op = CH_INSERT;
      end
      if (fc < bc) begin
        fc = fc + CW'(1);
        bc = bc - CW'(1);
      end else if ({1'b0, fc} > ({1'b0, bc} + (CW+1)'(1))) begin
        fc = fc - CW'(1);
        bc = bc + CW'(1);
      end
      front_count_next = fc;
      back_count_next  = bc;
    end
  end

  miq_chain #(
    .DEPTH (2 * HALF_DEPTH),
    .PW    (PW)
  ) u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .pos  (pos),
    .head (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front_count <= '0;
      back_count  <= '0;
      done        <= 1'b0;
    end else begin
      front_count <= front_count_next;
      back_count  <= back_count_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    served_value <= served_next;
    is_empty     <= empty_next;
  end

  a_done_from_serve: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && command == CMD_SERVE))
    else $error("result without a serve command");

  a_serve_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_SERVE) |=> done)
    else $error("serve command without a result");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (served_value == '0))
    else $error("empty serve with nonzero value");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (front_count <= FULL) && (back_count <= FULL))
    else $error("half count beyond depth");

  a_drop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_DROP && total != '0)
      |=> (total == $past(total) - TW'(1)))
    else $error("drop did not remove one entry");

endmodule
